// File: rtl/core/pkbe_pkg.sv
// Shared types, constants and helper functions for the prefix key block encoder.
// Used by pkbe_ctrl, pkbe_dp and prefix_key_block_encoder_core.
package pkbe_pkg;

  localparam int MAX_KEY_BYTES     = 20;
  localparam int RESTART_SLOTS     = 32;
  localparam int VALUE_LENGTH_BITS = 16;

  localparam int KEY_IDX_W  = $clog2(MAX_KEY_BYTES);
  localparam int KEY_LEN_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam int RS_IDX_W   = $clog2(RESTART_SLOTS);
  localparam int RS_CNT_W   = $clog2(RESTART_SLOTS + 1);
  localparam int VARINT_MAX = (VALUE_LENGTH_BITS + 6) / 7;
  localparam int HDR_MAX    = 2 + VARINT_MAX;
  localparam int HDR_IDX_W  = $clog2(HDR_MAX);
  localparam int HDR_LEN_W  = $clog2(HDR_MAX + 1);
  localparam int REC_LEN_W  = $clog2(HDR_MAX + MAX_KEY_BYTES + 1);
  localparam logic [7:0] RESTART_INTERVAL_RESET = 8'd16;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_KEY    = 2'd1,
    OP_VALUE  = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC,
    ST_FIN_RD,
    ST_FIN_OUT
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [4:0]  key_length;
    logic [15:0] value_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] chunk_data;
    logic [2:0]  chunk_bytes;
    logic        last_of_run;
    logic        restart_overflow;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rec_active;
    logic rec_step;
    logic fin_rd;
    logic fin_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic start_rec;
    logic start_fin;
    logic rec_need_out;
    logic rec_last;
    logic fin_last;
  } status_t;

  // varint bytes of a value length, lowest byte first
  function automatic logic [VARINT_MAX*8-1:0] varint_bytes(
      input logic [VALUE_LENGTH_BITS-1:0] v);
    logic [VARINT_MAX*8-1:0] r;
    logic [VARINT_MAX*7+6:0] w;
    r = '0;
    w = (VARINT_MAX*7+7)'(v);
    for (int i = 0; i < VARINT_MAX; i++) begin
      r[i*8 +: 7] = w[i*7 +: 7];
      r[i*8+7]    = ((w >> ((i + 1) * 7)) != '0);
    end
    return r;
  endfunction

  function automatic logic [HDR_LEN_W-1:0] varint_len(
      input logic [VALUE_LENGTH_BITS-1:0] v);
    logic [HDR_LEN_W-1:0] n;
    logic [VARINT_MAX*7+6:0] w;
    n = HDR_LEN_W'(1);
    w = (VARINT_MAX*7+7)'(v);
    for (int i = 1; i < VARINT_MAX; i++) begin
      if ((w >> (i * 7)) != '0) n = n + HDR_LEN_W'(1);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/prefix_key_block_encoder_core.sv
// Prefix key block encoder top level: pkbe_ctrl plus pkbe_dp, uses pkbe_pkg.
// A value byte is on the output the cycle after it is taken; a record that
// completes emits its n header/key bytes (n <= 25) one byte per cycle while
// the output is free, a chunk every 4 bytes, input stalled meanwhile. Finish emits
// one word per restart store read followed by its output step.
// Reset: synchronous, active high; clears control state, no clearing pass.
module prefix_key_block_encoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pkbe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pkbe_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  pkbe_pkg::cmd_t    cmd;
  pkbe_pkg::status_t st;

  pkbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pkbe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // no item is taken while a record or the trailer is being emitted
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.rec_active || cmd.fin_rd || cmd.fin_out) |-> in_stall)
    else $error("item accepted during emission");

  // chunk size stays within one word
  a_chunk_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.chunk_bytes != 3'd0 && out_item.chunk_bytes <= 3'd4))
    else $error("bad chunk size");

  // a trailer read is never directly followed by another read, only by its output step
  a_fin_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_rd |=> !cmd.fin_rd)
    else $error("trailer read repeated");

endmodule

// File: rtl/core/pkbe_ctrl.sv
// Controller state machine for the prefix key block encoder.
// Depends on pkbe_pkg; drives commands to pkbe_dp from its status.
module pkbe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pkbe_pkg::status_t st,
  output pkbe_pkg::cmd_t    cmd
);

  pkbe_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pkbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    in_stall       = !((state == pkbe_pkg::ST_IDLE) && st.out_free);
    cmd            = '0;
    cmd.accept     = in_valid && !in_stall;
    cmd.rec_active = (state == pkbe_pkg::ST_REC);
    case (state)
      pkbe_pkg::ST_IDLE: begin
        if (cmd.accept && st.start_rec) state_next = pkbe_pkg::ST_REC;
        else if (cmd.accept && st.start_fin) state_next = pkbe_pkg::ST_FIN_RD;
      end
      pkbe_pkg::ST_REC: begin
        cmd.rec_step = !st.rec_need_out || st.out_free;
        if (cmd.rec_step && st.rec_last) state_next = pkbe_pkg::ST_IDLE;
      end
      pkbe_pkg::ST_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_next = pkbe_pkg::ST_FIN_OUT;
      end
      pkbe_pkg::ST_FIN_OUT: begin
        cmd.fin_out = st.out_free;
        if (cmd.fin_out) begin
          state_next = st.fin_last ? pkbe_pkg::ST_IDLE : pkbe_pkg::ST_FIN_RD;
        end
      end
      default: state_next = pkbe_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/pkbe_dp.sv
// Datapath of the prefix key block encoder: key banks, restart store,
// record header builder, byte packer and output register. Depends on pkbe_pkg.
module pkbe_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  pkbe_pkg::in_item_t  in_item,
  input  pkbe_pkg::cmd_t      cmd,
  output pkbe_pkg::status_t   st,
  output logic                out_valid,
  input  logic                out_stall,
  output pkbe_pkg::out_item_t out_item
);

  localparam int KLW = pkbe_pkg::KEY_LEN_W;
  localparam int KIW = pkbe_pkg::KEY_IDX_W;
  localparam int VLB = pkbe_pkg::VALUE_LENGTH_BITS;
  localparam int NW  = pkbe_pkg::REC_LEN_W;
  localparam int HLW = pkbe_pkg::HDR_LEN_W;
  localparam int RCW = pkbe_pkg::RS_CNT_W;

  logic [7:0] interval;

  // two key banks; cur_sel picks the one being filled, the other is the previous key
  logic [7:0] kmem0 [pkbe_pkg::MAX_KEY_BYTES];
  logic [7:0] kmem1 [pkbe_pkg::MAX_KEY_BYTES];
  logic       cur_sel;
  logic [31:0] rs_mem [pkbe_pkg::RESTART_SLOTS];
  logic [31:0] rs_rd;

  logic [KLW-1:0] prev_len, pos, shared, key_len, ptr;
  logic           match, key_phase, ovf;
  logic [VLB-1:0] vlen;
  logic [7:0]     rec_cnt;
  logic [RCW-1:0] rs_cnt, fi;
  logic [31:0]    offset;
  logic [pkbe_pkg::HDR_MAX-1:0][7:0] hdr_buf;
  logic [HLW-1:0] hdr_len;
  logic [NW-1:0]  n_tot, e;
  logic [23:0]    acc;
  logic [1:0]     acc_n;

  pkbe_pkg::op_t  op;
  logic [KLW-1:0] klen_in, klen_eff, shared_raw, shared_f, nonshared;
  logic [VLB-1:0] vlen_eff;
  logic [KIW-1:0] rd_addr;
  logic [7:0]     prev_rd, rec_byte;
  logic           kb_ok, match_now, do_complete, restart, val_load, rec_load, fin_load;
  logic           clear;
  logic [HLW-1:0] vn;
  logic [pkbe_pkg::VARINT_MAX*8-1:0] vbytes;
  logic [31:0]    fin_word;
  logic           out_free;

  // input decode and prefix compare
  always_comb begin
    op      = in_item.opcode;
    klen_in = (KLW'(in_item.key_length) > KLW'(pkbe_pkg::MAX_KEY_BYTES)) ?
              KLW'(pkbe_pkg::MAX_KEY_BYTES) : KLW'(in_item.key_length);
    rd_addr = cmd.rec_active ? ptr[KIW-1:0] : pos[KIW-1:0];
    prev_rd = cur_sel ? kmem0[rd_addr] : kmem1[rd_addr];
    kb_ok   = (op == pkbe_pkg::OP_KEY) && key_phase && (pos < key_len);
    match_now = match && (pos < prev_len) && (prev_rd == in_item.data_byte);
  end

  // record header for a completed key
  always_comb begin
    klen_eff   = (op == pkbe_pkg::OP_BEGIN) ? '0 : key_len;
    shared_raw = (op == pkbe_pkg::OP_BEGIN) ? '0 : (shared + KLW'(match_now));
    vlen_eff   = (op == pkbe_pkg::OP_BEGIN) ? VLB'(in_item.value_length) : vlen;
    restart    = (rec_cnt >= interval);
    shared_f   = restart ? '0 : ((shared_raw > klen_eff) ? klen_eff : shared_raw);
    nonshared  = klen_eff - shared_f;
    vbytes     = pkbe_pkg::varint_bytes(vlen_eff);
    vn         = pkbe_pkg::varint_len(vlen_eff);
  end

  // status to the controller, record byte stream and packer
  always_comb begin
    st.start_rec    = ((op == pkbe_pkg::OP_BEGIN) && (klen_in == '0)) ||
                      (kb_ok && ((pos + KLW'(1)) >= key_len));
    st.start_fin    = (op == pkbe_pkg::OP_FINISH);
    do_complete     = cmd.accept && st.start_rec;
    out_free        = !out_valid || !out_stall;
    rec_byte        = (e < NW'(hdr_len)) ? hdr_buf[e[pkbe_pkg::HDR_IDX_W-1:0]] : prev_rd;
    st.out_free     = out_free;
    st.rec_last     = (e == (n_tot - NW'(1)));
    st.rec_need_out = (acc_n == 2'd3) || st.rec_last;
    st.fin_last     = (fi == rs_cnt);
    fin_word        = st.fin_last ? 32'(rs_cnt) : ((fi == '0) ? 32'd0 : rs_rd);
    val_load = cmd.accept && (op == pkbe_pkg::OP_VALUE) && !key_phase && (vlen != '0);
    rec_load = cmd.rec_step && st.rec_need_out;
    fin_load = cmd.fin_out;
    clear    = cmd.fin_out && st.fin_last;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.accept && kb_ok) begin
      if (cur_sel) kmem1[pos[KIW-1:0]] <= in_item.data_byte;
      else kmem0[pos[KIW-1:0]] <= in_item.data_byte;
    end
    if (do_complete && restart && (rs_cnt < RCW'(pkbe_pkg::RESTART_SLOTS))) begin
      rs_mem[rs_cnt[pkbe_pkg::RS_IDX_W-1:0]] <= offset;
    end
    if (cmd.fin_rd) rs_rd <= rs_mem[fi[pkbe_pkg::RS_IDX_W-1:0]];
  end

  // header payload registers
  always_ff @(posedge clk) begin
    if (do_complete) begin
      hdr_buf[0] <= 8'(shared_f);
      hdr_buf[1] <= 8'(nonshared);
      for (int i = 0; i < pkbe_pkg::VARINT_MAX; i++) hdr_buf[i+2] <= vbytes[i*8 +: 8];
      hdr_len <= HLW'(2) + vn;
      n_tot   <= NW'(HLW'(2) + vn) + NW'(nonshared);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prev_len  <= '0;
      pos       <= '0;
      shared    <= '0;
      key_len   <= '0;
      match     <= 1'b1;
      key_phase <= 1'b0;
      vlen      <= '0;
      rec_cnt   <= '0;
      rs_cnt    <= RCW'(1);
      offset    <= '0;
      ovf       <= 1'b0;
      acc       <= '0;
      acc_n     <= '0;
      e         <= '0;
      ptr       <= '0;
      fi        <= '0;
      cur_sel   <= 1'b0;
    end else begin
      if (cmd.accept && (op == pkbe_pkg::OP_BEGIN)) begin
        key_len   <= klen_in;
        vlen      <= VLB'(in_item.value_length);
        pos       <= '0;
        shared    <= '0;
        match     <= 1'b1;
        // an empty key completes at once, so no key bytes become due
        if (klen_in != '0) key_phase <= 1'b1;
      end
      if (cmd.accept && kb_ok) begin
        shared <= shared + KLW'(match_now);
        match  <= match_now;
        pos    <= pos + KLW'(1);
      end
      if (val_load) begin
        vlen   <= vlen - VLB'(1);
        offset <= offset + 32'd1;
      end
      if (cmd.accept && (op == pkbe_pkg::OP_FINISH)) fi <= '0;
      if (do_complete) begin
        key_phase <= 1'b0;
        prev_len  <= klen_eff;
        cur_sel   <= !cur_sel;
        offset    <= offset + 32'(NW'(HLW'(2) + vn) + NW'(nonshared));
        e         <= '0;
        ptr       <= shared_f;
        if (restart) begin
          rec_cnt <= '0;
          if (rs_cnt < RCW'(pkbe_pkg::RESTART_SLOTS)) rs_cnt <= rs_cnt + RCW'(1);
          else ovf <= 1'b1;
        end else begin
          rec_cnt <= rec_cnt + 8'd1;
        end
      end
      // byte packer
      if (cmd.rec_step) begin
        e <= e + NW'(1);
        if (e >= NW'(hdr_len)) ptr <= ptr + KLW'(1);
        if (st.rec_need_out) begin
          acc   <= '0;
          acc_n <= '0;
        end else begin
          acc[acc_n*8 +: 8] <= rec_byte;
          acc_n <= acc_n + 2'd1;
        end
      end
      if (cmd.fin_out) fi <= fi + RCW'(1);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= pkbe_pkg::RESTART_INTERVAL_RESET;
    end else if (cfg_we) begin
      interval <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (val_load || rec_load || fin_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (val_load) begin
      out_item <= '{chunk_data: 32'(in_item.data_byte), chunk_bytes: 3'd1,
                    last_of_run: 1'b1, restart_overflow: ovf};
    end else if (rec_load) begin
      out_item <= '{chunk_data: 32'(acc) | (32'(rec_byte) << {acc_n, 3'b000}),
                    chunk_bytes: 3'(acc_n) + 3'd1,
                    last_of_run: st.rec_last, restart_overflow: ovf};
    end else if (fin_load) begin
      out_item <= '{chunk_data: fin_word, chunk_bytes: 3'd4,
                    last_of_run: st.fin_last, restart_overflow: ovf};
    end
  end

endmodule
